/* rtl/ras_pkg.sv */
// ----------------------------------------------------------------------------
// ras_pkg
// Shared widths, limits, register map and controller/datapath interface types
// for the room allocation scheduler.
// ----------------------------------------------------------------------------
package ras_pkg;

    // field widths
    localparam int TIME_W  = 32;
    localparam int FREE_W  = 48;
    localparam int COUNT_W = 16;
    localparam int ROOM_W  = 4;
    localparam int RC_W    = 5;
    localparam int ENTRY_W = FREE_W + COUNT_W;

    // saturation limits
    localparam logic [FREE_W-1:0]  FREE_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // register file
    localparam int                 APB_ADDR_W     = 3;
    localparam int                 APB_DATA_W     = 32;
    localparam logic               REG_ROOM_COUNT = 1'b0;
    localparam logic [RC_W-1:0]    ROOM_COUNT_RST = 5'd16;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // latch the accepted meeting, restart the scan
        logic issue;     // scan phase: read the next room entry
        logic write;     // commit the chosen room and build the result
        logic out_load;  // move the result into the output register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_done; // every room entry read and folded in
        logic out_free;  // output register can take a new result
    } t_status;

endpackage

/* rtl/room_allocation_scheduler.sv */
// ----------------------------------------------------------------------------
// room_allocation_scheduler
// Meeting room allocator: each meeting takes the lowest free room, or the
// room that frees earliest with a delay, and the busiest room is reported.
//
//   channel   direction  handshake           payload
//   meeting   in         i_valid / o_stall   start_time, end_time, last_meeting
//   result    out        o_valid / i_stall   assigned_room .. batch_done
//   config    in         APB psel/penable    room_count at address 0
//
// For each meeting the scan reads one room entry a cycle from the single-port
// room table, then the chosen room's entry is written back.
// The result waits in an output register while the next meeting is taken.
// Synchronous active-low reset; no clearing pass, per-entry valid bits are
// dropped at once on reset and after the last meeting of a batch.
// ----------------------------------------------------------------------------
module room_allocation_scheduler #(
    parameter int MAX_ROOMS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // meeting channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [ras_pkg::TIME_W-1:0]      i_start_time,
    input  logic [ras_pkg::TIME_W-1:0]      i_end_time,
    input  logic                            i_last_meeting,
    // result channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [ras_pkg::ROOM_W-1:0]      o_assigned_room,
    output logic                            o_was_delayed,
    output logic [ras_pkg::ROOM_W-1:0]      o_busiest_room,
    output logic [ras_pkg::COUNT_W-1:0]     o_busiest_count,
    output logic                            o_order_error,
    output logic                            o_batch_done,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ras_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ras_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ras_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import ras_pkg::*;

    t_cmd            w_cmd;
    t_status         w_status;
    logic            w_busy;
    logic [RC_W-1:0] r_room_count;
    logic            w_sel_rc;

    // register decode
    assign w_sel_rc = (paddr[2] == REG_ROOM_COUNT);
    assign pready   = 1'b1;
    assign prdata   = w_sel_rc ? APB_DATA_W'(r_room_count) : '0;

    // room count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_room_count <= ROOM_COUNT_RST;
        end else if (psel && penable && pwrite && pready && w_sel_rc) begin
            r_room_count <= pwdata[RC_W-1:0];
        end
    end

    assign o_stall = w_busy;

    // controller
    ras_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    // datapath
    ras_datapath #(
        .MAX_ROOMS (MAX_ROOMS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_room_count    (r_room_count),
        .i_start_time    (i_start_time),
        .i_end_time      (i_end_time),
        .i_last_meeting  (i_last_meeting),
        .i_out_stall     (i_stall),
        .o_out_valid     (o_valid),
        .o_assigned_room (o_assigned_room),
        .o_was_delayed   (o_was_delayed),
        .o_busiest_room  (o_busiest_room),
        .o_busiest_count (o_busiest_count),
        .o_order_error   (o_order_error),
        .o_batch_done    (o_batch_done)
    );

endmodule

/* rtl/ras_ctrl.sv */
// ----------------------------------------------------------------------------
// ras_ctrl
// Sequencer for one meeting: accept, scan all rooms, write back, hand the
// result to the output register.
// ----------------------------------------------------------------------------
module ras_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  ras_pkg::t_status i_status,
    output ras_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    import ras_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* rtl/ras_datapath.sv */
// ----------------------------------------------------------------------------
// ras_datapath
// Room table memory with per-entry valid bits, scan trackers for the first
// free room, the earliest-freeing room and the busiest room, the write-back
// arithmetic and the output register.
// ----------------------------------------------------------------------------
module ras_datapath #(
    parameter int MAX_ROOMS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ras_pkg::t_cmd             i_cmd,
    output ras_pkg::t_status          o_status,
    input  logic [ras_pkg::RC_W-1:0]  i_room_count,
    input  logic [ras_pkg::TIME_W-1:0] i_start_time,
    input  logic [ras_pkg::TIME_W-1:0] i_end_time,
    input  logic                      i_last_meeting,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic [ras_pkg::ROOM_W-1:0] o_assigned_room,
    output logic                      o_was_delayed,
    output logic [ras_pkg::ROOM_W-1:0] o_busiest_room,
    output logic [ras_pkg::COUNT_W-1:0] o_busiest_count,
    output logic                      o_order_error,
    output logic                      o_batch_done
);
    import ras_pkg::*;

    localparam int IDX_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam int CNT_W = IDX_W + 1;

    // room table
    logic [ENTRY_W-1:0]   mem [MAX_ROOMS];
    logic [MAX_ROOMS-1:0] r_valid;

    // latched meeting
    logic [TIME_W-1:0]  r_start;
    logic [TIME_W-1:0]  r_len;
    logic               r_last;
    logic               r_order_err;
    logic [TIME_W-1:0]  r_prev_start;

    // scan pipeline
    logic [CNT_W-1:0]   r_idx;
    logic               r_rd_vld;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [ENTRY_W-1:0] r_rd_data;
    logic               r_rd_ev;

    // scan trackers
    logic               r_found;
    logic [IDX_W-1:0]   r_pf_idx;
    logic [COUNT_W-1:0] r_pf_ct;
    logic [IDX_W-1:0]   r_e_idx;
    logic [FREE_W-1:0]  r_e_ft;
    logic [COUNT_W-1:0] r_e_ct;
    logic [IDX_W-1:0]   r_b_idx;
    logic [COUNT_W-1:0] r_b_ct;

    // finished result
    logic [IDX_W-1:0]   r_res_room;
    logic               r_res_delayed;
    logic [IDX_W-1:0]   r_res_best;
    logic [COUNT_W-1:0] r_res_best_ct;

    // output register
    logic               r_out_valid;
    logic [ROOM_W-1:0]  r_out_room;
    logic               r_out_delayed;
    logic [ROOM_W-1:0]  r_out_best;
    logic [COUNT_W-1:0] r_out_best_ct;
    logic               r_out_order_err;
    logic               r_out_done;

    logic [CNT_W-1:0]   w_rooms;
    logic               w_rd_go;
    logic [FREE_W-1:0]  w_ft;
    logic [COUNT_W-1:0] w_ct;
    logic               w_first;
    logic [IDX_W-1:0]   w_pick;
    logic [COUNT_W-1:0] w_pick_ct;
    logic [FREE_W-1:0]  w_base;
    logic [FREE_W:0]    w_sum;
    logic [FREE_W-1:0]  w_fin;
    logic [COUNT_W-1:0] w_new_ct;
    logic [IDX_W-1:0]   w_best;
    logic [COUNT_W-1:0] w_best_ct;

    // rooms in use: zero acts as one, clamp to the built capacity
    always_comb begin
        if (i_room_count == '0) begin
            w_rooms = CNT_W'(1);
        end else if (int'(i_room_count) > MAX_ROOMS) begin
            w_rooms = CNT_W'(MAX_ROOMS);
        end else begin
            w_rooms = CNT_W'(i_room_count);
        end
    end

    assign w_rd_go            = i_cmd.issue && (r_idx != w_rooms);
    assign o_status.scan_done = (r_idx == w_rooms) && !r_rd_vld;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    // entry seen by the scan, unwritten entries read as zero
    assign w_ft    = r_rd_ev ? r_rd_data[ENTRY_W-1:COUNT_W] : '0;
    assign w_ct    = r_rd_ev ? r_rd_data[COUNT_W-1:0] : '0;
    assign w_first = (r_rd_idx == '0);

    // accept: latch fields, order check, meeting length
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_start     <= i_start_time;
            r_len       <= (i_end_time > i_start_time) ? (i_end_time - i_start_time) : '0;
            r_last      <= i_last_meeting;
            r_order_err <= (i_start_time < r_prev_start);
        end
    end

    // previous start, cleared after the last meeting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_start <= '0;
        end else if (i_cmd.load) begin
            r_prev_start <= i_last_meeting ? '0 : i_start_time;
        end
    end

    // scan address counter and read-valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_rd_vld <= w_rd_go;
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (w_rd_go) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    // registered memory read
    always_ff @(posedge i_clk) begin
        if (w_rd_go) begin
            r_rd_data <= mem[r_idx[IDX_W-1:0]];
            r_rd_ev   <= r_valid[r_idx[IDX_W-1:0]];
            r_rd_idx  <= r_idx[IDX_W-1:0];
        end
    end

    // fold one entry into the trackers
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            if (w_first) begin
                r_found  <= (w_ft <= FREE_W'(r_start));
                r_pf_idx <= '0;
                r_pf_ct  <= w_ct;
                r_e_idx  <= '0;
                r_e_ft   <= w_ft;
                r_e_ct   <= w_ct;
                r_b_idx  <= '0;
                r_b_ct   <= w_ct;
            end else begin
                if (!r_found && (w_ft <= FREE_W'(r_start))) begin
                    r_found  <= 1'b1;
                    r_pf_idx <= r_rd_idx;
                    r_pf_ct  <= w_ct;
                end
                if (w_ft < r_e_ft) begin
                    r_e_idx <= r_rd_idx;
                    r_e_ft  <= w_ft;
                    r_e_ct  <= w_ct;
                end
                if (w_ct > r_b_ct) begin
                    r_b_idx <= r_rd_idx;
                    r_b_ct  <= w_ct;
                end
            end
        end
    end

    // chosen room, new free time and new count
    assign w_pick    = r_found ? r_pf_idx : r_e_idx;
    assign w_pick_ct = r_found ? r_pf_ct : r_e_ct;
    assign w_base    = r_found ? FREE_W'(r_start) : r_e_ft;
    assign w_sum     = {1'b0, w_base} + (FREE_W + 1)'(r_len);
    assign w_fin     = w_sum[FREE_W] ? FREE_MAX : w_sum[FREE_W-1:0];
    assign w_new_ct  = (w_pick_ct == COUNT_MAX) ? w_pick_ct : (w_pick_ct + COUNT_W'(1));

    // busiest room after the increment of the chosen room
    always_comb begin
        w_best    = r_b_idx;
        w_best_ct = r_b_ct;
        if (w_pick == r_b_idx) begin
            w_best_ct = w_new_ct;
        end else if (w_new_ct > r_b_ct) begin
            w_best    = w_pick;
            w_best_ct = w_new_ct;
        end else if ((w_new_ct == r_b_ct) && (w_pick < r_b_idx)) begin
            w_best = w_pick;
        end
    end

    // room table write-back
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            mem[w_pick] <= {w_fin, w_new_ct};
        end
    end

    // entry valid bits, all dropped after the last meeting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.write) begin
            if (r_last) begin
                r_valid <= '0;
            end else begin
                r_valid[w_pick] <= 1'b1;
            end
        end
    end

    // hold the finished result
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_res_room    <= w_pick;
            r_res_delayed <= !r_found;
            r_res_best    <= w_best;
            r_res_best_ct <= w_best_ct;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_room      <= ROOM_W'(r_res_room);
            r_out_delayed   <= r_res_delayed;
            r_out_best      <= ROOM_W'(r_res_best);
            r_out_best_ct   <= r_res_best_ct;
            r_out_order_err <= r_order_err;
            r_out_done      <= r_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_assigned_room = r_out_room;
    assign o_was_delayed   = r_out_delayed;
    assign o_busiest_room  = r_out_best;
    assign o_busiest_count = r_out_best_ct;
    assign o_order_error   = r_out_order_err;
    assign o_batch_done    = r_out_done;

endmodule

/* tb/tb_room_allocation_scheduler.sv */
// ----------------------------------------------------------------------------
// tb_room_allocation_scheduler
// Self-checking bench for the meeting room allocator. Meetings go in on the
// valid/stall channel, each result transfer is checked field by field against
// an in-bench model of the room table, and room_count is swept over the APB
// port between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_room_allocation_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import ras_pkg::*;

    localparam int ROOMS         = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_TAIL    = 2 * ROOMS + 10;
    localparam int STUCK_LIMIT   = 4000;
    localparam int LONG_MEETINGS = 20;
    localparam int PHASE_ITEMS   = 72;
    localparam int MAX_REPORTS   = 40;
    localparam logic [TIME_W-1:0]     TIME_TOP        = '1;
    localparam logic [APB_ADDR_W-1:0] ROOM_COUNT_ADDR = APB_ADDR_W'(4 * REG_ROOM_COUNT);

    typedef struct {
        logic [ROOM_W-1:0]  room;
        logic               was_delayed;
        logic [ROOM_W-1:0]  busiest_room;
        logic [COUNT_W-1:0] busiest_count;
        logic               order_error;
        logic               batch_done;
    } t_meeting_result;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_valid        = 1'b0;
    logic                    o_stall;
    logic [TIME_W-1:0]       i_start_time   = '0;
    logic [TIME_W-1:0]       i_end_time     = '0;
    logic                    i_last_meeting = 1'b0;
    logic                    o_valid;
    logic                    i_stall        = 1'b0;
    logic [ROOM_W-1:0]       o_assigned_room;
    logic                    o_was_delayed;
    logic [ROOM_W-1:0]       o_busiest_room;
    logic [COUNT_W-1:0]      o_busiest_count;
    logic                    o_order_error;
    logic                    o_batch_done;
    logic                    psel           = 1'b0;
    logic                    penable        = 1'b0;
    logic                    pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr          = '0;
    logic [APB_DATA_W-1:0]   pwdata         = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    // mirror of the block state
    logic [RC_W-1:0]         room_count_reg;
    logic [FREE_W-1:0]       free_at [ROOMS];
    logic [COUNT_W-1:0]      uses [ROOMS];
    logic [TIME_W-1:0]       prev_start;
    t_meeting_result         room_results_q [$];

    int unsigned             errors       = 0;
    bit                      quiet        = 1'b0;
    int                      hold_asked   = 0;
    int                      hold_taken   = 0;
    int                      hold_left    = 0;
    int                      stuck_cycles = 0;

    room_allocation_scheduler #(.MAX_ROOMS(ROOMS)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_start_time    (i_start_time),
        .i_end_time      (i_end_time),
        .i_last_meeting  (i_last_meeting),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_assigned_room (o_assigned_room),
        .o_was_delayed   (o_was_delayed),
        .o_busiest_room  (o_busiest_room),
        .o_busiest_count (o_busiest_count),
        .o_order_error   (o_order_error),
        .o_batch_done    (o_batch_done),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int rooms_active();
        if (room_count_reg == 0) return 1;
        if (room_count_reg > ROOMS) return ROOMS;
        return int'(room_count_reg);
    endfunction

    function automatic void clear_rooms();
        foreach (free_at[i]) begin
            free_at[i] = '0;
            uses[i]    = '0;
        end
        prev_start = '0;
    endfunction

    // room choice, free time and use count update for one accepted meeting
    function automatic void allocate_room(input logic [TIME_W-1:0] st, en,
                                          input logic lst);
        logic [FREE_W-1:0] span;
        logic [FREE_W-1:0] base;
        logic [FREE_W:0]   fin;
        int                n;
        int                pick;
        int                earliest;
        int                best;
        bit                found;
        t_meeting_result   r;
        n = rooms_active();
        span = (en > st) ? FREE_W'(en - st) : '0;
        r.order_error = (st < prev_start);
        found = 1'b0;
        pick = 0;
        earliest = 0;
        for (int i = 0; i < n; i++) begin
            if (!found && free_at[i] <= FREE_W'(st)) begin
                pick = i;
                found = 1'b1;
            end
            if (free_at[i] < free_at[earliest]) earliest = i;
        end
        if (found) begin
            base = FREE_W'(st);
        end else begin
            pick = earliest;
            base = free_at[earliest];
        end
        fin = {1'b0, base} + {1'b0, span};
        free_at[pick] = (fin > {1'b0, FREE_MAX}) ? FREE_MAX : fin[FREE_W-1:0];
        if (uses[pick] != COUNT_MAX) uses[pick] = uses[pick] + 1'b1;
        best = 0;
        for (int i = 1; i < n; i++)
            if (uses[i] > uses[best]) best = i;
        r.room          = ROOM_W'(pick);
        r.was_delayed   = !found;
        r.busiest_room  = ROOM_W'(best);
        r.busiest_count = uses[best];
        r.batch_done    = lst;
        prev_start = st;
        if (lst) clear_rooms();
        room_results_q.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] got, want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // one meeting transfer, with random gaps ahead of it
    task automatic offer_meeting(input logic [TIME_W-1:0] st, en, input logic lst);
        while (!quiet && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_start_time   <= st;
        i_end_time     <= en;
        i_last_meeting <= lst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        allocate_room(st, en, lst);
    endtask

    // apb write of room_count, setup then access
    task automatic write_room_count(input logic [RC_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ROOM_COUNT_ADDR;
        pwdata  <= {(APB_DATA_W-RC_W)'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        room_count_reg = value;
        @(posedge i_clk);
    endtask

    // sender pauses until every result has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (room_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    task automatic test_directed();
        // reset room_count: field extremes, zero lengths, order flag, batch clear
        offer_meeting(32'd0, 32'd1, 1'b0);
        offer_meeting(32'd0, 32'd10, 1'b0);
        offer_meeting(32'd5, 32'd4, 1'b0);
        offer_meeting(32'd3, 32'd100, 1'b0);
        offer_meeting(TIME_TOP, TIME_TOP, 1'b0);
        offer_meeting(TIME_TOP, 32'd0, 1'b1);
        offer_meeting(32'd0, TIME_TOP, 1'b0);
        offer_meeting(32'h8000_0000, 32'h8000_0001, 1'b1);
        wait_drained();
        // two rooms: contention and earliest-free pick
        write_room_count(5'd2);
        offer_meeting(32'd10, 32'd20, 1'b0);
        offer_meeting(32'd10, 32'd30, 1'b0);
        offer_meeting(32'd10, 32'd40, 1'b0);
        offer_meeting(32'd15, 32'd16, 1'b0);
        offer_meeting(32'd16, 32'd17, 1'b0);
        offer_meeting(32'd100, 32'd101, 1'b1);
        wait_drained();
        // room_count zero acts as one, above capacity acts as capacity
        write_room_count(5'd0);
        offer_meeting(32'd7, 32'd9, 1'b0);
        offer_meeting(32'd7, 32'd9, 1'b1);
        wait_drained();
        write_room_count(5'd31);
        offer_meeting(32'd1, 32'd2, 1'b0);
        offer_meeting(32'd1, 32'd2, 1'b1);
        wait_drained();
    endtask

    // receiver holds off while meetings keep coming, so the input stalls
    task automatic test_back_pressure();
        write_room_count(5'd4);
        quiet = 1'b1;
        hold_asked++;
        for (int k = 0; k < 24; k++)
            offer_meeting(TIME_W'(k * 3), TIME_W'(k * 3 + 20), k == 23);
        quiet = 1'b0;
        wait_drained();
    endtask

    // sender pauses in the middle of an open batch
    task automatic test_source_pause();
        write_room_count(5'd3);
        for (int k = 0; k < 6; k++)
            offer_meeting(TIME_W'(100 + k), TIME_W'(140 + 2 * k), 1'b0);
        wait_drained();
        for (int k = 0; k < 6; k++)
            offer_meeting(TIME_W'(110 + k), TIME_W'(120 + k), k == 5);
        wait_drained();
    endtask

    // one batch: mostly ordered starts with overlap, some noise
    task automatic random_batch(input int n);
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] st;
        logic [TIME_W-1:0] en;
        int unsigned       roll;
        int unsigned       reach;
        reach = 8 * rooms_active();
        roll = $urandom_range(99);
        if (roll < 70)      t = $urandom_range(0, 2000);
        else if (roll < 90) t = $urandom();
        else                t = TIME_TOP - $urandom_range(0, 500);
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            if (roll < 85)      st = (t > TIME_TOP - 8) ? t : t + $urandom_range(0, 8);
            else if (roll < 93) st = t - $urandom_range(1, 50);
            else                st = $urandom();
            roll = $urandom_range(99);
            if (roll < 85)      en = st + $urandom_range(1, reach);
            else if (roll < 93) en = st - $urandom_range(0, 3);
            else                en = $urandom();
            offer_meeting(st, en, k == n - 1);
            t = st;
        end
    endtask

    // phases over room_count settings, one with no idling on either side
    task automatic test_random_phases();
        logic [RC_W-1:0] counts [12];
        int              sent;
        int              n;
        counts = '{5'd1, 5'd2, 5'd3, 5'd4, 5'd7, 5'd8, 5'd15, 5'd16,
                   5'd0, 5'd17, 5'd31, 5'd0};
        counts[11] = RC_W'($urandom_range(0, 31));
        foreach (counts[p]) begin
            write_room_count(counts[p]);
            quiet = (p == 5);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                n = $urandom_range(1, 30);
                random_batch(n);
                sent += n;
            end
            quiet = 1'b0;
            wait_drained();
        end
    endtask

    // one room, longest meetings: free time piles up far past 32 bits
    task automatic test_long_meetings();
        write_room_count(5'd0);
        for (int k = 0; k < LONG_MEETINGS; k++)
            offer_meeting('0, TIME_TOP, k == LONG_MEETINGS - 1);
        wait_drained();
    endtask

    // receiver stall: random, or a long counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_asked != hold_taken) begin
            hold_left = HOLD_CYCLES;
            hold_taken = hold_asked;
        end
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= !quiet && ($urandom_range(99) < 6);
        end
    end

    // result transfer check against the oldest pending result
    always @(posedge i_clk) begin
        t_meeting_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (room_results_q.size() == 0) begin
                report_mismatch("result with none pending", 48'd1, 48'd0);
            end else begin
                want = room_results_q.pop_front();
                if (o_assigned_room !== want.room)
                    report_mismatch("assigned_room", 48'(o_assigned_room), 48'(want.room));
                if (o_was_delayed !== want.was_delayed)
                    report_mismatch("was_delayed", 48'(o_was_delayed),
                                    48'(want.was_delayed));
                if (o_busiest_room !== want.busiest_room)
                    report_mismatch("busiest_room", 48'(o_busiest_room),
                                    48'(want.busiest_room));
                if (o_busiest_count !== want.busiest_count)
                    report_mismatch("busiest_count", 48'(o_busiest_count),
                                    48'(want.busiest_count));
                if (o_order_error !== want.order_error)
                    report_mismatch("order_error", 48'(o_order_error),
                                    48'(want.order_error));
                if (o_batch_done !== want.batch_done)
                    report_mismatch("batch_done", 48'(o_batch_done), 48'(want.batch_done));
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // reset, then the tests in turn
    initial begin
        room_count_reg = ROOM_COUNT_RST;
        clear_rooms();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_back_pressure();
        test_source_pause();
        test_random_phases();
        test_long_meetings();
        if (errors == 0 && room_results_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
